FILE: src/fcsn_pkg.sv
// fcsn_pkg: shared types and codes of the flow classifier with sequence numbering
// used by fcsn_ctrl, fcsn_datapath and flow_classifier_seq_numbering_top
package fcsn_pkg;

    localparam int FLOW_NUM_W = 6;
    localparam int SEQ_W      = 32;
    localparam int KEY_W      = 96;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } pkt_t;

    typedef struct packed {
        logic                  tagged_res;
        logic [FLOW_NUM_W-1:0] flow_number;
        logic [SEQ_W-1:0]      seq_number;
        logic                  new_flow;
        logic                  table_full;
    } res_t;

    typedef logic [1:0] res_kind_t;

    localparam res_kind_t RES_PASS = 2'd0;
    localparam res_kind_t RES_FULL = 2'd1;
    localparam res_kind_t RES_TAG  = 2'd2;

    // register word index on the config port
    localparam logic REG_COLLECT = 1'b0;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      take_hit;
        logic      take_miss;
        logic      upd;
        logic      emit;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic full;
    } stat_t;

endpackage

FILE: src/fcsn_ctrl.sv
// fcsn_ctrl: sequencing state machine of the flow classifier
// depends on fcsn_pkg for command and status types
module fcsn_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           collect_enable,
    input  fcsn_pkg::stat_t stat,
    output fcsn_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SEQRD = 2'd2;
    localparam logic [1:0] ST_SEQWR = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = fcsn_pkg::RES_PASS;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (!collect_enable)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = fcsn_pkg::RES_PASS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_SEQRD;
                end
                else if (stat.miss)
                begin
                    if (stat.full)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = fcsn_pkg::RES_FULL;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.take_miss = 1'b1;
                        state_next    = ST_SEQRD;
                    end
                end
            end
            ST_SEQRD:
            begin
                state_next = ST_SEQWR;
            end
            ST_SEQWR:
            begin
                cmd.upd    = 1'b1;
                cmd.emit   = 1'b1;
                cmd.kind   = fcsn_pkg::RES_TAG;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: src/fcsn_datapath.sv
// fcsn_datapath: flow key and sequence memories, search pointer, flow count, result register
// depends on fcsn_pkg; driven by fcsn_ctrl commands
module fcsn_datapath
#(
    parameter int MAX_FLOWS = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  fcsn_pkg::pkt_t  pkt,
    input  fcsn_pkg::cmd_t  cmd,
    output fcsn_pkg::stat_t stat,
    output logic            done,
    output fcsn_pkg::res_t  res
);

    localparam int IDX_W = $clog2(MAX_FLOWS);
    localparam int CNT_W = $clog2(MAX_FLOWS + 1);

    logic [fcsn_pkg::KEY_W-1:0] key_mem [MAX_FLOWS];
    logic [fcsn_pkg::SEQ_W-1:0] seq_mem [MAX_FLOWS];

    fcsn_pkg::pkt_t             key_reg;
    logic [fcsn_pkg::KEY_W-1:0] key_q_reg;
    logic [fcsn_pkg::SEQ_W-1:0] seq_q_reg;
    logic [CNT_W-1:0]           rd_idx_reg;
    logic                       cmp_vld_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       new_reg;
    logic                       done_reg;
    fcsn_pkg::res_t             res_reg;

    logic                       issue;
    logic [fcsn_pkg::SEQ_W-1:0] seq_next;
    fcsn_pkg::res_t             res_next;

    assign issue    = cmd.scan && (rd_idx_reg != count_reg);
    assign seq_next = (new_reg ? '0 : seq_q_reg) + 32'd1;

    assign stat.hit  = cmp_vld_reg && (key_q_reg == key_reg);
    assign stat.miss = !cmp_vld_reg && (rd_idx_reg == count_reg);
    assign stat.full = (count_reg == CNT_W'(MAX_FLOWS));

    // flow key memory
    always_ff @(posedge clk)
    begin
        if (cmd.upd && new_reg)
        begin
            key_mem[idx_reg] <= key_reg;
        end
        if (issue)
        begin
            key_q_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // sequence counter memory
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            seq_mem[idx_reg] <= seq_next;
        end
        seq_q_reg <= seq_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= pkt;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.take_hit)
        begin
            idx_reg <= cmp_idx_reg;
            new_reg <= 1'b0;
        end
        else if (cmd.take_miss)
        begin
            idx_reg <= count_reg[IDX_W-1:0];
            new_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.load)
            begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.upd && new_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        case (cmd.kind)
            fcsn_pkg::RES_FULL:
            begin
                res_next.table_full = 1'b1;
            end
            fcsn_pkg::RES_TAG:
            begin
                res_next.tagged_res  = 1'b1;
                res_next.flow_number = fcsn_pkg::FLOW_NUM_W'(idx_reg);
                res_next.seq_number  = seq_next;
                res_next.new_flow    = new_reg;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: src/flow_classifier_seq_numbering_top.sv
// flow_classifier_seq_numbering_top: apb register, controller and datapath of the flow classifier
// depends on fcsn_pkg, fcsn_ctrl and fcsn_datapath

// A packet is taken when start is high while busy is low; its result appears on res for one
// cycle with done high and must be captured then. With collection off the result follows in the
// cycle after start. Otherwise the stored flow keys are read from the key memory one entry per
// clock, lowest flow first, until a hit or until all stored flows are read; a hit or a new flow
// then reads and updates the flow's sequence counter before its tagged result, while a full
// table gives an untagged table-full result. busy stays high until done, and a new
// packet can be started in the cycle that done is high.
module flow_classifier_seq_numbering_top
#(
    parameter int MAX_FLOWS = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fcsn_pkg::pkt_t pkt,
    output logic           done,
    output fcsn_pkg::res_t res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic            collect_enable_reg;
    logic            cfg_wr;
    fcsn_pkg::cmd_t  cmd;
    fcsn_pkg::stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collect_enable_reg <= 1'b0;
        end
        else if (cfg_wr && (paddr[2] == fcsn_pkg::REG_COLLECT))
        begin
            collect_enable_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            fcsn_pkg::REG_COLLECT:
            begin
                prdata = {31'd0, collect_enable_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    fcsn_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .collect_enable (collect_enable_reg),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy)
    );

    fcsn_datapath
    #(
        .MAX_FLOWS (MAX_FLOWS)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .res   (res)
    );

    // collection off gives an untagged result right away
    a_pass_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !collect_enable_reg) |=> (done && !res.tagged_res))
        else $error("untagged result missing after start");

    // an accepted packet keeps the block busy or finishes at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted packet dropped");

    // a new flow is always a tagged, non-overflow result
    a_new_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.new_flow) |-> (res.tagged_res && !res.table_full))
        else $error("new flow result not tagged");

    // overflow and tagging never come together
    a_full_untag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.table_full) |-> (!res.tagged_res && !res.new_flow))
        else $error("table full result carries a tag");

endmodule
